// File: rtl/bffa_pkg.sv
// shared constants, codes, command/status structs and the padding function
// for the best-fit free-list allocator; no dependencies
package bffa_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 21;
  localparam int PAD_W  = 8;

  // allocation geometry (alignment must be a power of two)
  localparam int ALIGN        = 16;
  localparam int ALIGN_W      = $clog2(ALIGN);
  localparam int HEADER_BYTES = 16;
  localparam int NODE_BYTES   = 16;

  localparam int DEF_MAX_EXTENTS = 16;
  localparam int DEF_MAX_RECORDS = 16;

  localparam logic [LEN_W-1:0] ARENA_MAX = 21'd1048576;
  localparam logic [LEN_W-1:0] ARENA_RST = 21'd65536;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_BYTES = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_a;
    logic scan_r;
    logic prep_e;
    logic scan_e;
    logic decide;
    logic commit;
    logic shift;
    logic place;
    logic init_wr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic init_req;
    logic req_valid;
    logic req_free;
    logic req_null;
    logic scan_end;
    logic hit;
    logic need_shift;
    logic place_pend;
    logic shift_done;
    logic out_free;
  } sts_t;

  // distance from an extent start to the aligned user address
  function automatic logic [PAD_W-1:0] pad_for(input logic [ALIGN_W-1:0] rem);
    logic [PAD_W-1:0] p;
    p = (rem == '0) ? '0 : PAD_W'(ALIGN) - PAD_W'(rem);
    for (int i = 0; i < 8; i++) begin
      if (p < PAD_W'(HEADER_BYTES)) p = p + PAD_W'(ALIGN);
    end
    return p;
  endfunction

endpackage

// File: rtl/bffa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bffa_ctrl.sv
// sequencing state machine of the allocator
// depends on bffa_pkg
module bffa_ctrl import bffa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN_A = 4'd2;
  localparam logic [3:0] S_SCAN_R = 4'd3;
  localparam logic [3:0] S_CHK_R  = 4'd4;
  localparam logic [3:0] S_SCAN_E = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_SHIFT  = 4'd8;
  localparam logic [3:0] S_PLACE  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        if (sts.req_valid) begin
          cmd.load = 1'b1;
          if (!sts.req_free) state_nxt = S_SCAN_A;
          else if (sts.req_null) state_nxt = S_FIN;
          else state_nxt = S_SCAN_R;
        end
      end
      S_SCAN_A: begin
        cmd.scan_a = 1'b1;
        if (sts.scan_end) state_nxt = S_COMMIT;
      end
      S_SCAN_R: begin
        cmd.scan_r = 1'b1;
        if (sts.scan_end) state_nxt = S_CHK_R;
      end
      S_CHK_R: begin
        if (sts.hit) begin
          cmd.prep_e = 1'b1;
          state_nxt  = S_SCAN_E;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_SCAN_E: begin
        cmd.scan_e = 1'b1;
        if (sts.scan_end) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.need_shift ? S_SHIFT : S_FIN;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) state_nxt = sts.place_pend ? S_PLACE : S_FIN;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (sts.init_req) state_nxt = S_INIT;
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end

endmodule

// File: rtl/bffa_dp.sv
// allocator datapath: extent and record rams, scan, update and shift logic
// depends on bffa_pkg and bffa_ram
module bffa_dp import bffa_pkg::*; #(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 in_valid,
  input  logic                 in_mode,
  input  logic [LEN_W-1:0]     in_req_size,
  input  logic [ADDR_W-1:0]    in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [ADDR_W-1:0]    out_user_address,
  output logic [LEN_W-1:0]     out_block_bytes,
  output logic [LEN_W-1:0]     out_used_bytes,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int IW     = $clog2(MAX_EXTENTS);
  localparam int CTW    = IW + 1;
  localparam int RW     = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int SCAN_N = (MAX_EXTENTS > MAX_RECORDS) ? MAX_EXTENTS : MAX_RECORDS;
  localparam int KW     = $clog2(SCAN_N + 1);
  localparam int LW     = (KW > CTW) ? KW : CTW;
  localparam int EXT_W  = ADDR_W + LEN_W;
  localparam int REC_W  = ADDR_W + LEN_W + PAD_W;

  // configuration and arena state
  logic [ADDR_W-1:0]      base_r;
  logic [LEN_W-1:0]       abytes_r;
  logic [CTW-1:0]         count_r;
  logic [MAX_RECORDS-1:0] valid_r;
  logic [LEN_W-1:0]       biu_r;

  // request
  logic              mode_r;
  logic [LEN_W-1:0]  size_r;
  logic [ADDR_W-1:0] addr_r;

  // scan
  logic [KW-1:0] k_r, kd_r;
  logic          rdv_r;

  logic              found_r;
  logic [IW-1:0]     best_idx_r;
  logic [ADDR_W-1:0] best_start_r;
  logic [LEN_W-1:0]  best_len_r;
  logic [PAD_W-1:0]  best_pad_r;
  logic [LEN_W:0]    best_diff_r;
  logic              slot_ok_r;
  logic [RW-1:0]     slot_r;

  logic              hit_r;
  logic [PAD_W-1:0]  rec_pad_r;
  logic [LEN_W-1:0]  rec_bb_r;
  logic [ADDR_W-1:0] fstart_r;
  logic              poshit_r, prev_v_r, jn_r, jp_r;
  logic [CTW-1:0]    pos_r;
  logic [ADDR_W-1:0] prev_start_r, next_start_r;
  logic [LEN_W-1:0]  prev_len_r, next_len_r;

  // shift engine
  logic           sh_up_r, shv_r, place_pend_r;
  logic [CTW-1:0] sh_idx_r, shd_r, sh_n_r;

  // results
  logic [1:0]        res_status_r;
  logic [ADDR_W-1:0] res_ua_r;
  logic [LEN_W-1:0]  res_bb_r;
  logic              out_valid_r;

  // ram ports
  logic             ext_we;
  logic [IW-1:0]    ext_waddr, ext_raddr;
  logic [EXT_W-1:0] ext_wdata, ext_rdata;
  logic             rec_we;
  logic [REC_W-1:0] rec_wdata, rec_rdata;

  logic [ADDR_W-1:0] e_start, r_ua;
  logic [LEN_W-1:0]  e_len, r_bb;
  logic [PAD_W-1:0]  r_pad, e_pad;
  logic [LEN_W:0]    e_want, e_diff;
  logic              e_fit, kd_in, scan_issue, shift_issue;

  logic [LEN_W:0]    need_a, rem_a;
  logic              split, alloc_ok, free_none, free_full;
  logic [LEN_W-1:0]  grant, bytes_sat;
  logic [ADDR_W-1:0] alloc_ua;
  logic [CTW-1:0]    pos_m1, shw;

  assign e_start = ext_rdata[EXT_W-1:LEN_W];
  assign e_len   = ext_rdata[LEN_W-1:0];
  assign r_ua    = rec_rdata[REC_W-1:LEN_W+PAD_W];
  assign r_bb    = rec_rdata[LEN_W+PAD_W-1:PAD_W];
  assign r_pad   = rec_rdata[PAD_W-1:0];

  assign e_pad  = pad_for(e_start[ALIGN_W-1:0]);
  assign e_want = {1'b0, size_r} + (LEN_W+1)'(e_pad);
  assign e_fit  = {1'b0, e_len} >= e_want;
  assign e_diff = {1'b0, e_len} - e_want;
  assign kd_in  = LW'(kd_r) < LW'(count_r);

  assign scan_issue = ((cmd.scan_a || cmd.scan_e) && (k_r < KW'(MAX_EXTENTS))) ||
                      (cmd.scan_r && (k_r < KW'(MAX_RECORDS)));
  assign shift_issue = cmd.shift && (sh_n_r != '0);

  assign need_a   = {1'b0, size_r} + (LEN_W+1)'(best_pad_r);
  assign rem_a    = {1'b0, best_len_r} - need_a;
  assign split    = rem_a >= (LEN_W+1)'(NODE_BYTES);
  assign alloc_ok = found_r && slot_ok_r;
  assign grant    = split ? need_a[LEN_W-1:0] : best_len_r;
  assign alloc_ua = best_start_r + ADDR_W'(best_pad_r);

  assign free_none = !jn_r && !jp_r;
  assign free_full = free_none && (count_r >= CTW'(MAX_EXTENTS));
  assign pos_m1    = pos_r - CTW'(1);
  assign shw       = sh_up_r ? shd_r + CTW'(1) : shd_r - CTW'(1);
  assign bytes_sat = (cfg_wdata[LEN_W-1:0] > ARENA_MAX) ? ARENA_MAX : cfg_wdata[LEN_W-1:0];

  assign ext_raddr = cmd.shift ? sh_idx_r[IW-1:0] : k_r[IW-1:0];

  // single extent write port, one user per cycle
  always_comb begin
    ext_we    = 1'b0;
    ext_waddr = '0;
    ext_wdata = {base_r, abytes_r};
    if (cmd.init_wr) begin
      ext_we = 1'b1;
    end else if (cmd.commit && !mode_r && alloc_ok && split) begin
      ext_we    = 1'b1;
      ext_waddr = best_idx_r;
      ext_wdata = {best_start_r + ADDR_W'(need_a), rem_a[LEN_W-1:0]};
    end else if (cmd.commit && mode_r && hit_r && !free_full && !free_none) begin
      ext_we = 1'b1;
      if (jn_r && jp_r) begin
        ext_waddr = pos_m1[IW-1:0];
        ext_wdata = {prev_start_r, prev_len_r + rec_bb_r + next_len_r};
      end else if (jn_r) begin
        ext_waddr = pos_r[IW-1:0];
        ext_wdata = {fstart_r, next_len_r + rec_bb_r};
      end else begin
        ext_waddr = pos_m1[IW-1:0];
        ext_wdata = {prev_start_r, prev_len_r + rec_bb_r};
      end
    end else if (shv_r) begin
      ext_we    = 1'b1;
      ext_waddr = shw[IW-1:0];
      ext_wdata = ext_rdata;
    end else if (cmd.place) begin
      ext_we    = 1'b1;
      ext_waddr = pos_r[IW-1:0];
      ext_wdata = {fstart_r, rec_bb_r};
    end
  end

  assign rec_we    = cmd.commit && !mode_r && alloc_ok;
  assign rec_wdata = {alloc_ua, grant, best_pad_r - PAD_W'(HEADER_BYTES)};

  bffa_ram #(.WIDTH(EXT_W), .DEPTH(MAX_EXTENTS), .AW(IW)) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  bffa_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS), .AW(RW)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (slot_r),
    .wdata (rec_wdata),
    .raddr (k_r[RW-1:0]),
    .rdata (rec_rdata)
  );

  always_comb begin
    sts            = '0;
    sts.init_req   = cfg_we && (cfg_index == REG_ARENA_BYTES);
    sts.req_valid  = in_valid;
    sts.req_free   = in_mode;
    sts.req_null   = (in_address == '0);
    sts.scan_end   = (k_r == KW'(SCAN_N));
    sts.hit        = hit_r;
    sts.need_shift = mode_r ? (hit_r && ((jn_r && jp_r) || (free_none && !free_full)))
                            : (alloc_ok && !split);
    sts.place_pend = place_pend_r;
    sts.shift_done = (sh_n_r == '0) && !shv_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      abytes_r     <= ARENA_RST;
      count_r      <= CTW'(1);
      valid_r      <= '0;
      biu_r        <= '0;
      rdv_r        <= 1'b0;
      shv_r        <= 1'b0;
      sh_n_r       <= '0;
      place_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rdv_r <= scan_issue;
      kd_r  <= k_r;

      if (cmd.load || cmd.prep_e) k_r <= '0;
      else if ((cmd.scan_a || cmd.scan_r || cmd.scan_e) && (k_r != KW'(SCAN_N)))
        k_r <= k_r + KW'(1);

      if (cmd.load) begin
        mode_r       <= in_mode;
        size_r       <= (in_req_size < LEN_W'(NODE_BYTES)) ? LEN_W'(NODE_BYTES) : in_req_size;
        addr_r       <= in_address;
        found_r      <= 1'b0;
        slot_ok_r    <= 1'b0;
        hit_r        <= 1'b0;
        place_pend_r <= 1'b0;
        res_status_r <= ST_OK;
        res_ua_r     <= '0;
        res_bb_r     <= '0;
      end

      // best fit over extents, first free record in the same pass
      if (cmd.scan_a && rdv_r && kd_in && e_fit && (!found_r || e_diff < best_diff_r)) begin
        found_r      <= 1'b1;
        best_idx_r   <= kd_r[IW-1:0];
        best_start_r <= e_start;
        best_len_r   <= e_len;
        best_pad_r   <= e_pad;
        best_diff_r  <= e_diff;
      end
      if (cmd.scan_a && (k_r < KW'(MAX_RECORDS)) && !slot_ok_r && !valid_r[k_r[RW-1:0]]) begin
        slot_ok_r <= 1'b1;
        slot_r    <= k_r[RW-1:0];
      end

      // record lookup
      if (cmd.scan_r && rdv_r && !hit_r && valid_r[kd_r[RW-1:0]] && (r_ua == addr_r)) begin
        hit_r     <= 1'b1;
        slot_r    <= kd_r[RW-1:0];
        rec_pad_r <= r_pad;
        rec_bb_r  <= r_bb;
      end

      if (cmd.prep_e) begin
        fstart_r <= addr_r - ADDR_W'(HEADER_BYTES) - ADDR_W'(rec_pad_r);
        poshit_r <= 1'b0;
        prev_v_r <= 1'b0;
      end

      // insertion point: first extent starting above the freed block
      if (cmd.scan_e && rdv_r && kd_in && !poshit_r) begin
        if (e_start > fstart_r) begin
          poshit_r     <= 1'b1;
          pos_r        <= CTW'(kd_r);
          next_start_r <= e_start;
          next_len_r   <= e_len;
        end else begin
          prev_v_r     <= 1'b1;
          prev_start_r <= e_start;
          prev_len_r   <= e_len;
        end
      end

      if (cmd.decide) begin
        if (!poshit_r) pos_r <= count_r;
        jn_r <= poshit_r && ((fstart_r + ADDR_W'(rec_bb_r)) == next_start_r);
        jp_r <= prev_v_r && ((prev_start_r + ADDR_W'(prev_len_r)) == fstart_r);
      end

      if (cmd.commit) begin
        if (!mode_r) begin
          if (!found_r) res_status_r <= ST_NO_FIT;
          else if (!slot_ok_r) res_status_r <= ST_FULL;
          else begin
            valid_r[slot_r] <= 1'b1;
            biu_r    <= biu_r + grant;
            res_ua_r <= alloc_ua;
            res_bb_r <= grant;
            if (!split) begin
              count_r  <= count_r - CTW'(1);
              sh_up_r  <= 1'b0;
              sh_idx_r <= CTW'(best_idx_r) + CTW'(1);
              sh_n_r   <= count_r - CTW'(best_idx_r) - CTW'(1);
            end
          end
        end else begin
          if (!hit_r) res_status_r <= ST_UNKNOWN;
          else if (free_full) res_status_r <= ST_FULL;
          else begin
            valid_r[slot_r] <= 1'b0;
            biu_r    <= (biu_r >= rec_bb_r) ? biu_r - rec_bb_r : '0;
            res_bb_r <= rec_bb_r;
            if (jn_r && jp_r) begin
              count_r  <= count_r - CTW'(1);
              sh_up_r  <= 1'b0;
              sh_idx_r <= pos_r + CTW'(1);
              sh_n_r   <= count_r - pos_r - CTW'(1);
            end else if (free_none) begin
              count_r      <= count_r + CTW'(1);
              sh_up_r      <= 1'b1;
              sh_idx_r     <= count_r - CTW'(1);
              sh_n_r       <= count_r - pos_r;
              place_pend_r <= 1'b1;
            end
          end
        end
      end

      shv_r <= shift_issue;
      if (shift_issue) begin
        shd_r    <= sh_idx_r;
        sh_idx_r <= sh_up_r ? sh_idx_r - CTW'(1) : sh_idx_r + CTW'(1);
        sh_n_r   <= sh_n_r - CTW'(1);
      end

      if (cmd.fin) begin
        out_valid_r      <= 1'b1;
        out_status       <= res_status_r;
        out_user_address <= res_ua_r;
        out_block_bytes  <= res_bb_r;
        out_used_bytes   <= biu_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // configuration writes win over everything else
      if (cfg_we) begin
        if (cfg_index == REG_ARENA_BASE) begin
          base_r <= cfg_wdata;
        end else begin
          abytes_r <= bytes_sat;
          count_r  <= CTW'(1);
          valid_r  <= '0;
          biu_r    <= '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/best_fit_free_list_allocator.sv
// top level of the best-fit free-list allocator
// depends on bffa_pkg, bffa_ctrl, bffa_dp (which holds the bffa_ram instances)

// Best-fit allocator over one arena. Free space is a start-ordered table of
// extents and each granted block has a record. A word on the input channel is
// an allocate (mode 0) or a free (mode 1); each word gives exactly one result
// word. One request is worked at a time. An allocate scans the extent and
// record tables in one pass and then commits; when it uses up an extent, a
// table shift closes the gap. A free of a known pointer scans the records,
// then the extents, decides on merges and commits; a merge of both
// neighbours adds the same shift, and an insert adds a shift plus a step to
// place the new extent. A null free goes straight to its result and a free
// of an unknown pointer ends after the record scan. The time of a request is
// set by the scans, which walk the extent ram and the record ram one entry
// per cycle through their single read port, and by the table shifts through
// the same port. A new request is taken while the previous result still
// waits in the output register; a finished result waits until that register
// is free. Writing arena_bytes (and reset) reinitialises the arena; the
// block is busy after that while the first extent is written. ALIGN must be
// a power of two.
module best_fit_free_list_allocator import bffa_pkg::*; #(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [LEN_W-1:0]     in_req_size,
  input  logic [ADDR_W-1:0]    in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [ADDR_W-1:0]    out_user_address,
  output logic [LEN_W-1:0]     out_block_bytes,
  output logic [LEN_W-1:0]     out_used_bytes,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: scan, commit, shift and output steps
  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // tables, scan evaluation and the output register
  bffa_dp #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_valid         (in_valid),
    .in_mode          (in_mode),
    .in_req_size      (in_req_size),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_user_address (out_user_address),
    .out_block_bytes  (out_block_bytes),
    .out_used_bytes   (out_used_bytes),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

`ifndef SYNTH
  // one request at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a request is in progress");

  // a finished request always reaches the output register
  a_fin_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid)
    else $error("result not presented after finish");

  // the sequencer issues at most one step per cycle
  a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath step at once");
`endif

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for best_fit_free_list_allocator
// depends on bffa_pkg and the allocator rtl; holds its own allocator predictor
`timescale 1ns / 1ps

module tb;
  import bffa_pkg::*;

  localparam int N_EXT = DEF_MAX_EXTENTS;
  localparam int N_REC = DEF_MAX_RECORDS;
  localparam int STALL_LIMIT = 20000;

  // expected result word
  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] user_address;
    logic [LEN_W-1:0]  block_bytes;
    logic [LEN_W-1:0]  used_bytes;
  } result_t;

  // allocator predictor and queue of expected result words
  class alloc_scoreboard;
    logic [ADDR_W-1:0] base_latch;
    logic [LEN_W-1:0]  size_latch;
    logic [ADDR_W-1:0] ext_start [N_EXT];
    logic [LEN_W-1:0]  ext_len [N_EXT];
    int                ext_n;
    logic [ADDR_W-1:0] rec_addr [N_REC];
    logic [LEN_W-1:0]  rec_bytes [N_REC];
    logic [PAD_W-1:0]  rec_pad [N_REC];
    bit                rec_live [N_REC];
    logic [LEN_W-1:0]  in_use;
    result_t           pending [$];
    int                mismatches;
    int                n_checked;
    int                n_ok, n_nofit, n_full, n_unknown;

    function void reinit();
      for (int i = 0; i < N_EXT; i++) begin
        ext_start[i] = '0;
        ext_len[i] = '0;
      end
      ext_start[0] = base_latch;
      ext_len[0] = size_latch;
      ext_n = 1;
      for (int i = 0; i < N_REC; i++) rec_live[i] = 0;
      in_use = '0;
    endfunction

    function void power_up();
      base_latch = '0;
      size_latch = ARENA_RST;
      reinit();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] v);
      logic [LEN_W-1:0] l;
      if (idx == REG_ARENA_BASE) begin
        base_latch = v;
      end else begin
        l = v[LEN_W-1:0];
        size_latch = (l > ARENA_MAX) ? ARENA_MAX : l;
        reinit();
      end
    endfunction

    function logic [31:0] padding(logic [ADDR_W-1:0] s);
      logic [31:0] r, p;
      r = s % ALIGN;
      p = (r != 0) ? ALIGN - r : 0;
      if (p < HEADER_BYTES) p += ALIGN * ((HEADER_BYTES - p + ALIGN - 1) / ALIGN);
      return p;
    endfunction

    function void drop_extent(int pos);
      for (int i = pos; i + 1 < ext_n; i++) begin
        ext_start[i] = ext_start[i+1];
        ext_len[i] = ext_len[i+1];
      end
      if (ext_n > 0) ext_n--;
    endfunction

    function result_t grant(logic [LEN_W-1:0] req);
      result_t r;
      logic [31:0] sz, pad, best_pad, need, left, st;
      longint diff, want;
      int best, slot;
      r = '0;
      sz = (req < NODE_BYTES) ? NODE_BYTES : req;
      diff = -1;
      best = -1;
      best_pad = 0;
      for (int i = 0; i < ext_n; i++) begin
        pad = padding(ext_start[i]);
        want = longint'(sz) + pad;
        if (longint'(ext_len[i]) >= want &&
            (diff < 0 || longint'(ext_len[i]) - want < diff)) begin
          diff = longint'(ext_len[i]) - want;
          best = i;
          best_pad = pad;
        end
      end
      if (best < 0) begin
        r.status = ST_NO_FIT;
        return r;
      end
      slot = -1;
      for (int i = 0; i < N_REC; i++) if (!rec_live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        r.status = ST_FULL;
        return r;
      end
      need = sz + best_pad;
      left = ext_len[best] - need;
      st = ext_start[best];
      if (left >= NODE_BYTES) begin
        ext_start[best] = st + need;
        ext_len[best] = left[LEN_W-1:0];
      end else begin
        need = ext_len[best];
        drop_extent(best);
      end
      rec_addr[slot] = st + best_pad;
      rec_bytes[slot] = need[LEN_W-1:0];
      rec_pad[slot] = 8'(best_pad - HEADER_BYTES);
      rec_live[slot] = 1;
      in_use = in_use + need[LEN_W-1:0];
      r.status = ST_OK;
      r.user_address = rec_addr[slot];
      r.block_bytes = need[LEN_W-1:0];
      return r;
    endfunction

    function result_t release_block(logic [ADDR_W-1:0] a);
      result_t r;
      int slot, pos;
      logic [ADDR_W-1:0] fs;
      logic [LEN_W-1:0] fl;
      bit jn, jp;
      r = '0;
      if (a == 0) return r;
      slot = -1;
      for (int i = 0; i < N_REC; i++)
        if (slot < 0 && rec_live[i] && rec_addr[i] == a) slot = i;
      if (slot < 0) begin
        r.status = ST_UNKNOWN;
        return r;
      end
      fs = a - HEADER_BYTES - rec_pad[slot];
      fl = rec_bytes[slot];
      pos = 0;
      while (pos < ext_n && ext_start[pos] <= fs) pos++;
      jn = (pos < ext_n) && (ADDR_W'(fs + fl) == ext_start[pos]);
      jp = (pos > 0) && (ADDR_W'(ext_start[pos-1] + ext_len[pos-1]) == fs);
      if (!jn && !jp && ext_n >= N_EXT) begin
        r.status = ST_FULL;
        return r;
      end
      if (jn && jp) begin
        ext_len[pos-1] = ext_len[pos-1] + fl + ext_len[pos];
        drop_extent(pos);
      end else if (jn) begin
        ext_start[pos] = fs;
        ext_len[pos] = ext_len[pos] + fl;
      end else if (jp) begin
        ext_len[pos-1] = ext_len[pos-1] + fl;
      end else begin
        for (int i = ext_n; i > pos; i--) begin
          ext_start[i] = ext_start[i-1];
          ext_len[i] = ext_len[i-1];
        end
        ext_start[pos] = fs;
        ext_len[pos] = fl;
        ext_n++;
      end
      rec_live[slot] = 0;
      in_use = (in_use >= fl) ? in_use - fl : '0;
      r.block_bytes = fl;
      return r;
    endfunction

    // note an accepted request word
    function void note_request(logic m, logic [LEN_W-1:0] sz, logic [ADDR_W-1:0] a);
      result_t r;
      r = m ? release_block(a) : grant(sz);
      r.used_bytes = in_use;
      pending.push_back(r);
    endfunction

    // check one accepted result word against the oldest expectation
    function void check_result(result_t got);
      result_t exp_r;
      n_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_r = pending.pop_front();
      case (exp_r.status)
        ST_OK:      n_ok++;
        ST_NO_FIT:  n_nofit++;
        ST_FULL:    n_full++;
        default:    n_unknown++;
      endcase
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp st=%0d ua=%h bb=%0d ub=%0d got st=%0d ua=%h bb=%0d ub=%0d",
                   n_checked, exp_r.status, exp_r.user_address, exp_r.block_bytes,
                   exp_r.used_bytes, got.status, got.user_address, got.block_bytes,
                   got.used_bytes);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_mode;
  logic [LEN_W-1:0] in_req_size;
  logic [ADDR_W-1:0] in_address;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [ADDR_W-1:0] out_user_address;
  logic [LEN_W-1:0] out_block_bytes, out_used_bytes;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;

  best_fit_free_list_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_req_size(in_req_size), .in_address(in_address),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_user_address(out_user_address), .out_block_bytes(out_block_bytes),
    .out_used_bytes(out_used_bytes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  alloc_scoreboard sb;
  int idle_cycles;
  bit hold_sink;        // set by the stimulus to ask for a long receiver stall
  logic [ADDR_W-1:0] granted [$];   // user addresses believed live, to aim frees at

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // accepted word bookkeeping on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_mode, in_req_size, in_address);
        if (!in_mode && sb.pending[$].status == ST_OK)
          granted.push_back(sb.pending[$].user_address);
      end
      if (out_valid && out_ready)
        sb.check_result({out_status, out_user_address, out_block_bytes, out_used_bytes});
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random ready gaps, plus a long hold-off on request
  initial begin
    int g, n;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ready <= 0;
        for (n = 0; n < 400; n++) @(negedge clk);
        hold_sink = 0;
      end
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) == 0) begin
        out_ready <= 1;
      end else begin
        out_ready <= 0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // offer one request word and hold it until accepted; valid is dropped by
  // the next call's gap or by drain
  task automatic send_word(logic m, logic [LEN_W-1:0] sz, logic [ADDR_W-1:0] a,
                           bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_mode <= m;
    in_req_size <= sz;
    in_address <= a;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // register write, only while idle
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] v);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    if (idx == REG_ARENA_BYTES) granted.delete();
    repeat (2) @(negedge clk);
  endtask

  task automatic send_alloc(logic [LEN_W-1:0] sz, bit no_gap = 0);
    send_word(0, sz, $urandom(), no_gap);
  endtask

  // free a granted block, drawn at random from those still live; a null free if none is left
  task automatic send_free_live();
    int k;
    logic [ADDR_W-1:0] a;
    if (granted.size() == 0) begin
      send_word(1, LEN_W'($urandom()), 0);
      return;
    end
    k = $urandom_range(0, granted.size() - 1);
    a = granted[k];
    granted.delete(k);
    send_word(1, LEN_W'($urandom()), a);
  endtask

  // small random size, mostly within a few nodes
  function automatic logic [LEN_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return LEN_W'($urandom_range(0, 64));
    if (r < 90) return LEN_W'($urandom_range(0, 2048));
    if (r < 97) return LEN_W'($urandom_range(0, 65536));
    return LEN_W'($urandom_range(0, 21'h1fffff));
  endfunction

  task automatic random_phase(int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_alloc(rand_size());
      else if (r < 90) send_free_live();
      else if (r < 94) send_word(1, LEN_W'($urandom()), 0);
      else if (r < 98) send_word(1, LEN_W'($urandom()), $urandom());
      else if (granted.size() > 0)
        send_word(1, LEN_W'($urandom()), granted[0] + 16);   // near miss pointer
      else send_alloc(LEN_W'($urandom()));
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] bases [6];
    logic [ADDR_W-1:0] sizes [6];
    sb = new();
    sb.power_up();
    sb.mismatches = 0;
    idle_cycles = 0;
    hold_sink = 0;
    rst_n = 0;
    in_valid = 0;
    in_mode = 0;
    in_req_size = '0;
    in_address = '0;
    cfg_we = 0;
    cfg_index = REG_ARENA_BASE;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    repeat (4) @(negedge clk);

    // directed: reset arena, extremes of sizes, null free, unknown pointer
    send_alloc(0);
    send_alloc(21'h1fffff);
    send_alloc(65536);
    send_alloc(1);
    send_word(1, 21'h1fffff, 0);
    send_word(1, 0, 32'hffffffff);
    send_free_live();
    send_free_live();

    // base off the alignment near the top of the address space; oversized arena saturates
    write_cfg(REG_ARENA_BASE, 32'hffff_fff8);
    write_cfg(REG_ARENA_BYTES, 32'hffff_ffff);
    send_alloc(16);               // wraps round the top of the address space
    send_alloc(1048576);          // no fit
    send_free_live();

    // arena of zero bytes: nothing fits
    write_cfg(REG_ARENA_BYTES, 0);
    send_alloc(0);

    // fill the record table, then table full on allocate
    write_cfg(REG_ARENA_BASE, 32'h0000_1008);
    write_cfg(REG_ARENA_BYTES, 4096);
    for (int i = 0; i < 17; i++) send_alloc(16, 1);
    // free every other block so the extent table grows, then merges
    for (int i = 0; i < 16; i += 2) send_word(1, 0, granted[i]);
    for (int i = 1; i < 16; i += 2) send_word(1, 0, granted[i]);
    granted.delete();
    drain();

    // pressure: receiver holds off while requests keep coming
    hold_sink = 1;
    for (int i = 0; i < 12; i++) send_alloc(rand_size(), 1);
    drain();

    // random phases across several arena settings
    bases = '{32'h0, 32'h8000_0008, 32'hffff_0000, 32'h1234_5678, 32'h10, 32'hfff0_0000};
    sizes = '{65536, 512, 1048576, 2048, 256, 300};
    for (int p = 0; p < 6; p++) begin
      write_cfg(REG_ARENA_BASE, bases[p] & 32'hffff_fff8);
      write_cfg(REG_ARENA_BYTES, sizes[p]);
      random_phase(130);
      // sender pause until every result has arrived
      drain();
      random_phase(130);
    end
    hold_sink = 1;
    random_phase(40);

    drain();
    repeat (100) @(negedge clk);
    $display("covered %0d results: %0d ok, %0d no fit, %0d table full, %0d unknown pointer",
             sb.n_checked, sb.n_ok, sb.n_nofit, sb.n_full, sb.n_unknown);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: best_fit_free_list_allocator.f
rtl/bffa_pkg.sv
rtl/bffa_ram.sv
rtl/bffa_ctrl.sv
rtl/bffa_dp.sv
rtl/best_fit_free_list_allocator.sv
tb/sv/tb.sv
